>>> rtl/core/scf_pkg.sv
// Shared constants and types for the sine/cosine continued-fraction core.
// Used by every module under rtl/core.
`timescale 1ns / 1ps

package scf_pkg;

  // continued-fraction depth
  localparam int TERMS = 4;

  // divider geometry: quotient bits, divisor and dividend widths
  localparam int DIV_QB = 32;
  localparam int DEN_W  = 36;
  localparam int NUM_W  = DEN_W + DIV_QB;

  // angle constants, Q.32 radians, rounded to nearest; ONE_Q30 is one in Q.30
  localparam logic signed [36:0] PI_Q32    = 37'sh03243F6A89;
  localparam logic signed [36:0] TWOPI_Q32 = 37'sh06487ED511;
  localparam logic [32:0]        PIH_Q32   = 33'h1921FB544;
  localparam logic [31:0]        PIQ_Q32   = 32'hC90FDAA2;
  localparam logic [31:0]        ONE_Q30   = 32'h40000000;

  // data that travels alongside the divider pipelines
  typedef struct packed {
    logic [30:0] h;     // half angle, Q.32
    logic [31:0] h2;    // h squared, Q.32
    logic        neg;   // negate sine
    logic        cneg;  // negate cosine
    logic        swp;   // octant swap
  } side_t;

endpackage

>>> rtl/core/scf_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on scf_pkg (widths, side_t carried alongside).
`timescale 1ns / 1ps

module scf_div import scf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [DIV_QB-1:0] out_quot,
  output side_t             out_side
);

  // quotient must be below 2^DIV_QB, so the top part of num starts below den
  logic [DIV_QB-1:0] v_r;
  logic [DEN_W-1:0]  rem_r  [DIV_QB];
  logic [DIV_QB-1:0] nlo_r  [DIV_QB];
  logic [DIV_QB-1:0] q_r    [DIV_QB];
  logic [DEN_W-1:0]  den_r  [DIV_QB];
  side_t             side_r [DIV_QB];

  for (genvar k = 0; k < DIV_QB; k++) begin : g_stage
    logic              v_in;
    logic [DEN_W-1:0]  rem_in;
    logic [DIV_QB-1:0] nlo_in;
    logic [DIV_QB-1:0] q_in;
    logic [DEN_W-1:0]  den_in;
    side_t             side_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_num[NUM_W-1:DIV_QB];
      assign nlo_in  = in_num[DIV_QB-1:0];
      assign q_in    = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign nlo_in  = nlo_r[k-1];
      assign q_in    = q_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      trial = {rem_in, nlo_in[DIV_QB-1]};
      diff  = trial - {1'b0, den_in};
      ge    = (trial >= {1'b0, den_in});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
      rem_r[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nlo_r[k]  <= {nlo_in[DIV_QB-2:0], 1'b0};
      q_r[k]    <= {q_in[DIV_QB-2:0], ge};
      den_r[k]  <= den_in;
      side_r[k] <= side_in;
    end
  end

  assign out_valid = v_r[DIV_QB-1];
  assign out_quot  = q_r[DIV_QB-1];
  assign out_side  = side_r[DIV_QB-1];

endmodule

>>> rtl/core/scf_reduce.sv
// Range reduction: wrap, sign fold, quadrant and octant mapping, half angle
// and its square. Six register stages. Depends on scf_pkg.
`timescale 1ns / 1ps

module scf_reduce import scf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [31:0] in_angle,
  output logic        out_valid,
  output side_t       out_side
);

  logic [5:0] v_r;
  logic signed [36:0] aw_r, aw_nxt, a_s;
  logic [33:0] x2_r;
  logic        neg2_r, neg3_r, neg4_r, neg5_r;
  logic [32:0] x3_r, x3_nxt;
  logic        cneg3_r, cneg4_r, cneg5_r;
  logic [31:0] y4_r, y4_nxt;
  logic        swp4_r, swp5_r;
  logic [30:0] h5_r;
  logic [61:0] p5_r;
  logic [36:0] absv;
  logic [32:0] pih_minus;
  logic [62:0] p_rnd;
  side_t       side_r;

  always_comb begin
    a_s = {in_angle[31], in_angle, 4'b0000};
    if (a_s < -PI_Q32)     aw_nxt = a_s + TWOPI_Q32;
    else if (a_s > PI_Q32) aw_nxt = a_s - TWOPI_Q32;
    else                   aw_nxt = a_s;
    absv = aw_r[36] ? 37'(-aw_r) : 37'(aw_r);
    // |a| up to pi needs all 34 bits here
    x3_nxt = (x2_r > {1'b0, PIH_Q32}) ? 33'(x2_r - {1'b0, PIH_Q32})
                                      : x2_r[32:0];
    pih_minus = PIH_Q32 - x3_r;
    y4_nxt = (x3_r > {1'b0, PIQ_Q32}) ? pih_minus[31:0] : x3_r[31:0];
    p_rnd  = {1'b0, p5_r} + 63'h80000000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], in_valid};
    end
    // stage 1: wrap into [-pi, pi]
    aw_r    <= aw_nxt;
    // stage 2: fold sign
    neg2_r  <= aw_r[36];
    x2_r    <= absv[33:0];
    // stage 3: second quadrant onto first
    neg3_r  <= neg2_r;
    cneg3_r <= (x2_r > {1'b0, PIH_Q32});
    x3_r    <= x3_nxt;
    // stage 4: above pi/4 mapped below it
    neg4_r  <= neg3_r;
    cneg4_r <= cneg3_r;
    swp4_r  <= (x3_r > {1'b0, PIQ_Q32});
    y4_r    <= y4_nxt;
    // stage 5: half angle squared
    neg5_r  <= neg4_r;
    cneg5_r <= cneg4_r;
    swp5_r  <= swp4_r;
    h5_r    <= y4_r[31:1];
    p5_r    <= y4_r[31:1] * y4_r[31:1];
    // stage 6: round the square
    side_r.h    <= h5_r;
    side_r.h2   <= p_rnd[62:31] >> 1;
    side_r.neg  <= neg5_r;
    side_r.cneg <= cneg5_r;
    side_r.swp  <= swp5_r;
  end

  assign out_valid = v_r[5];
  assign out_side  = side_r;

endmodule

>>> rtl/core/scf_cf.sv
// Continued fraction for t = tan(h): TERMS divider sections in a chain,
// each with two setup stages. Depends on scf_pkg and scf_div.
`timescale 1ns / 1ps

module scf_cf import scf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [31:0] out_t,
  output side_t       out_side
);

  logic [TERMS-1:0] tv;
  logic [31:0]      tq [TERMS];
  side_t            ts [TERMS];

  for (genvar k = 0; k < TERMS; k++) begin : g_term
    localparam int N = TERMS - 1 - k;
    logic             v_in;
    logic [31:0]      t_in;
    side_t            s_in;
    logic [1:0]       v_r;
    logic [DEN_W-1:0] den_r, den2_r, den_nxt;
    logic [NUM_W-1:0] num_r, num_nxt;
    side_t            s1_r, s2_r;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign t_in = '0;
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = tv[k-1];
      assign t_in = tq[k-1];
      assign s_in = ts[k-1];
    end

    if (N >= 1) begin : g_round
      // t = round(h2 / ((2n+1) - t))
      always_comb begin
        den_nxt = {4'(2 * N + 1), 32'h0} - {4'h0, t_in};
        num_nxt = {4'h0, s1_r.h2, 32'h0} + {33'h0, den_r[DEN_W-1:1]};
      end
    end else begin : g_last
      // t = h / (1 - t), truncated
      always_comb begin
        den_nxt = {4'h1, 32'h0} - {4'h0, t_in};
        num_nxt = {5'h0, s1_r.h, 32'h0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= '0;
      end else begin
        v_r <= {v_r[0], v_in};
      end
      den_r  <= den_nxt;
      s1_r   <= s_in;
      den2_r <= den_r;
      num_r  <= num_nxt;
      s2_r   <= s1_r;
    end

    scf_div u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v_r[1]),
      .in_num    (num_r),
      .in_den    (den2_r),
      .in_side   (s2_r),
      .out_valid (tv[k]),
      .out_quot  (tq[k]),
      .out_side  (ts[k])
    );
  end

  assign out_valid = tv[TERMS-1];
  assign out_t     = tq[TERMS-1];
  assign out_side  = ts[TERMS-1];

endmodule

>>> rtl/core/scf_recon.sv
// Sine and cosine from t: t^2, the two divisions by 1 + t^2, saturation,
// swap and sign restore. Depends on scf_pkg and scf_div.
`timescale 1ns / 1ps

module scf_recon import scf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [31:0] in_t,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [31:0] out_sine_value,
  output logic [31:0] out_cosine_value
);

  logic [3:0]       v_r;
  logic [31:0]      t1_r, t2t_r, t3_r;
  logic [63:0]      p1_r;
  logic [31:0]      sq2_r, sq3_r;
  logic [32:0]      cm3_r;
  logic [64:0]      p_rnd;
  side_t            s1_r, s2_r, s3_r, s4_r;
  logic [NUM_W-1:0] nums_r, numc_r;
  logic [DEN_W-1:0] den4_r;
  logic             dvs, dvc;
  logic [31:0]      qs, qc;
  side_t            sds, sdc;
  logic             v5_r, swap5_r, neg5_r, cneg5_r;
  logic [31:0]      s5_r, c5_r, sm, cm;
  logic             vo_r;
  logic [31:0]      so_r, co_r;

  always_comb begin
    p_rnd = {1'b0, p1_r} + 65'h80000000;
    sm = swap5_r ? c5_r : s5_r;
    cm = swap5_r ? s5_r : c5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      v5_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v_r  <= {v_r[2:0], in_valid};
      v5_r <= dvs & dvc;
      vo_r <= v5_r;
    end
    // t squared
    t1_r  <= in_t;
    p1_r  <= in_t * in_t;
    s1_r  <= in_side;
    t2t_r <= t1_r;
    sq2_r <= p_rnd[63:32];
    s2_r  <= s1_r;
    // 1 - t^2
    t3_r  <= t2t_r;
    sq3_r <= sq2_r;
    cm3_r <= 33'h100000000 - {1'b0, sq2_r};
    s3_r  <= s2_r;
    // dividends with half the divisor added for rounding
    nums_r <= {5'h0, t3_r, 31'h0} + {36'h0, 1'b1, sq3_r[31:1]};
    numc_r <= {5'h0, cm3_r, 30'h0} + {36'h0, 1'b1, sq3_r[31:1]};
    den4_r <= {3'h0, 1'b1, sq3_r};
    s4_r   <= s3_r;
    // saturate to one
    s5_r    <= (qs > ONE_Q30) ? ONE_Q30 : qs;
    c5_r    <= (qc > ONE_Q30) ? ONE_Q30 : qc;
    swap5_r <= sdc.swp ^ sdc.cneg;
    neg5_r  <= sds.neg;
    cneg5_r <= sdc.cneg;
    // swap and signs
    so_r <= neg5_r  ? 32'(-sm) : sm;
    co_r <= cneg5_r ? 32'(-cm) : cm;
  end

  scf_div u_div_s (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_r[3]),
    .in_num    (nums_r),
    .in_den    (den4_r),
    .in_side   (s4_r),
    .out_valid (dvs),
    .out_quot  (qs),
    .out_side  (sds)
  );

  scf_div u_div_c (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_r[3]),
    .in_num    (numc_r),
    .in_den    (den4_r),
    .in_side   (s4_r),
    .out_valid (dvc),
    .out_quot  (qc),
    .out_side  (sdc)
  );

  assign out_valid        = vo_r;
  assign out_sine_value   = so_r;
  assign out_cosine_value = co_r;

endmodule

>>> rtl/core/sine_cosine_continued_fraction_core.sv
// Top level of the sine/cosine unit: reduction, continued fraction, output.
// Depends on scf_pkg, scf_reduce, scf_cf, scf_recon (and scf_div below them).
//
// Usage:
//   Drive in_angle (signed Q3.28 radians) and pulse start; the item is taken
//   at any edge where start is high and busy is low. busy is always low, so
//   one item can enter every cycle, back to back.
//   Each item yields one result: out_sine_value and out_cosine_value
//   (signed Q1.30, saturated to +/-1) are shown for exactly one cycle with
//   out_valid high. Results leave in the order items came in.
//   An item passes through the reduction, then TERMS continued-fraction
//   sections, then the reconstruction. Most of the pipeline lies in the
//   restoring dividers, one quotient bit per stage, 32 stages each, TERMS
//   of them in series for the continued fraction and one more pair for
//   the final sine and cosine.
//   Throughput: one item per cycle.
//   Reset (rst_n low, synchronous) clears all valid bits; items in flight
//   are dropped. The receiver cannot stall: out_valid is a strobe.
`timescale 1ns / 1ps

module sine_cosine_continued_fraction_core import scf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_angle,
  output logic        out_valid,
  output logic [31:0] out_sine_value,
  output logic [31:0] out_cosine_value
);

  logic        red_v, cf_v;
  side_t       red_side, cf_side;
  logic [31:0] cf_t;

  assign busy = 1'b0;

  scf_reduce u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .in_angle  (in_angle),
    .out_valid (red_v),
    .out_side  (red_side)
  );

  scf_cf u_cf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (red_v),
    .in_side   (red_side),
    .out_valid (cf_v),
    .out_t     (cf_t),
    .out_side  (cf_side)
  );

  scf_recon u_recon (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (cf_v),
    .in_t             (cf_t),
    .in_side          (cf_side),
    .out_valid        (out_valid),
    .out_sine_value   (out_sine_value),
    .out_cosine_value (out_cosine_value)
  );

endmodule
